FILE: src/utf8_bmp_stream_decoder_unit_assert.svh
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_BMP_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_BMP_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define U8B_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define U8B_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/utf8bmp_pkg.sv
// Types and constants shared by the UTF-8 decoder modules.
`default_nettype none
package utf8bmp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CP_W      = 16;
  localparam int unsigned LEN_W     = 2;
  localparam int unsigned PARTIAL_W = 10;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [LEN_W-1:0] LEN_NONE  = 2'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

  localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 16'h0080;
  localparam logic [CP_W-1:0] MIN_THREE_BYTE = 16'h0800;

  typedef struct packed {
    logic [PARTIAL_W-1:0] partial;
    logic [LEN_W-1:0]     due;
    logic [LEN_W-1:0]     total;
  } dec_state_t;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic             status;
    logic [LEN_W-1:0] seq_length;
    logic             eos;
  } dec_result_t;

  localparam dec_state_t STATE_IDLE = '{partial: '0, due: LEN_NONE, total: LEN_NONE};

endpackage
`default_nettype wire

FILE: src/utf8bmp_step.sv
// Per-byte UTF-8 decode step: state and byte in, next state and optional result out.
`default_nettype none
module utf8bmp_step (
  input  wire  utf8bmp_pkg::dec_state_t         state_i,
  input  wire  logic [utf8bmp_pkg::BYTE_W-1:0]  byte_i,
  output utf8bmp_pkg::dec_state_t               state_o,
  output utf8bmp_pkg::dec_result_t              res_o
);
  import utf8bmp_pkg::*;

  logic [LEN_W-1:0] len_so_far;
  logic [CP_W-1:0]  val_two;
  logic [CP_W-1:0]  val_three;

  // bytes of the sequence so far, counting this one
  assign len_so_far = LEN_W'(state_i.total - state_i.due + LEN_ONE);
  assign val_two    = {5'd0, state_i.partial[4:0], byte_i[5:0]};
  assign val_three  = {state_i.partial, byte_i[5:0]};

  always_comb begin
    state_o = STATE_IDLE;
    res_o   = '0;
    if (state_i.due == LEN_NONE) begin
      priority if (byte_i[7] == 1'b0) begin
        res_o.valid      = 1'b1;
        res_o.code_point = {8'd0, byte_i};
        res_o.status     = STATUS_OK;
        res_o.seq_length = LEN_ONE;
        res_o.eos        = (byte_i == '0);
      end else if (byte_i[7:5] == 3'b110) begin
        state_o.partial = {5'd0, byte_i[4:0]};
        state_o.due     = LEN_ONE;
        state_o.total   = LEN_TWO;
      end else if (byte_i[7:4] == 4'b1110) begin
        state_o.partial = {6'd0, byte_i[3:0]};
        state_o.due     = LEN_TWO;
        state_o.total   = LEN_THREE;
      end else begin
        // stray continuation or four-byte-and-up lead
        res_o.valid      = 1'b1;
        res_o.status     = STATUS_ERR;
        res_o.seq_length = LEN_ONE;
      end
    end else begin
      priority if (byte_i[7:6] != 2'b10) begin
        // bad continuation: byte dropped, not retried as a lead
        res_o.valid      = 1'b1;
        res_o.status     = STATUS_ERR;
        res_o.seq_length = len_so_far;
      end else if (state_i.due > LEN_ONE) begin
        state_o.partial = {state_i.partial[3:0], byte_i[5:0]};
        state_o.due     = LEN_W'(state_i.due - LEN_ONE);
        state_o.total   = state_i.total;
      end else if (state_i.total == LEN_TWO) begin
        res_o.valid      = 1'b1;
        res_o.seq_length = LEN_TWO;
        if (val_two < MIN_TWO_BYTE) begin
          res_o.status = STATUS_ERR;
        end else begin
          res_o.status     = STATUS_OK;
          res_o.code_point = val_two;
        end
      end else begin
        res_o.valid      = 1'b1;
        res_o.seq_length = LEN_THREE;
        if (val_three < MIN_THREE_BYTE) begin
          res_o.status = STATUS_ERR;
        end else begin
          res_o.status     = STATUS_OK;
          res_o.code_point = val_three;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/utf8_bmp_stream_decoder_unit.sv
// Top level of the streaming UTF-8 (one to three byte) to 16-bit code point decoder.
// A result reaches out_* through the input register, the decode step and the result register, in that order.
// Throughput: one byte per cycle; the input register and the result register each
// take a new beat whenever the stage after them is free, so a held output only
// stalls the input once both registers are full.
// Reset: synchronous, active-low rst_n empties both registers and returns the decoder to idle.
`default_nettype none
`include "utf8_bmp_stream_decoder_unit_assert.svh"
module utf8_bmp_stream_decoder_unit (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst_n,
  // input byte stream
  input  wire  logic                                 in_tvalid,
  output logic                                       in_tready,
  input  wire  logic [utf8bmp_pkg::BYTE_W-1:0]       in_tdata,  // [7:0] byte_in
  // decoded characters
  output logic                                       out_tvalid,
  input  wire  logic                                 out_tready,
  output logic [utf8bmp_pkg::OUT_DATA_W-1:0]         out_tdata, // [15:0] code_point,
                                                                // [17:16] seq_length,
                                                                // [23:18] zero
  output logic                                       out_tuser, // [0] status (1 = error)
  output logic                                       out_tlast  // end_of_string
);
  import utf8bmp_pkg::*;

  // Input register: one byte beat waiting for the decode step.
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;

  // Decoder state carried between bytes of one sequence.
  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_state_t  step_state;
  dec_result_t step_res;

  // Result register feeding the output port.
  dec_result_t res_r;
  dec_result_t res_nxt;

  logic advance;  // byte in the input register is decoded this cycle

  utf8bmp_step u_step (
    .state_i (state_r),
    .byte_i  (in_byte_r),
    .state_o (step_state),
    .res_o   (step_res)
  );

  // The decode step may run whenever the result register is free or drains now;
  // bytes that give no result still need the slot, which keeps ordering trivial.
  assign advance   = in_valid_r && (!res_r.valid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    state_nxt    = state_r;
    res_nxt      = res_r;
    if (res_r.valid && out_tready) begin
      res_nxt.valid = 1'b0;
    end
    if (advance) begin
      state_nxt    = step_state;
      in_valid_nxt = 1'b0;
      if (step_res.valid) begin
        res_nxt = step_res;
      end
    end
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end
  end

  // Result payload is left alone in reset; only its valid flag is cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      state_r     <= STATE_IDLE;
      res_r.valid <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      state_r     <= state_nxt;
      res_r       <= res_nxt;
    end
  end

  // Input byte register, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  assign out_tvalid = res_r.valid;
  assign out_tdata  = {{(OUT_DATA_W - CP_W - LEN_W){1'b0}}, res_r.seq_length, res_r.code_point};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.eos;

  // Error beats carry no character and never mark the terminator.
  `U8B_ASSERT_IMP(a_err_clean, out_tvalid && out_tuser,
    out_tdata[CP_W-1:0] == '0 && !out_tlast, "error beat with payload")
  // Terminator is always the single-byte zero.
  `U8B_ASSERT_IMP(a_eos_shape, out_tvalid && out_tlast,
    out_tdata[CP_W-1:0] == '0 && out_tdata[CP_W+LEN_W-1:CP_W] == LEN_ONE,
    "terminator beat malformed")
  // Mid-sequence state only ever belongs to a two- or three-byte form.
  `U8B_ASSERT_IMP(a_state_sane, state_r.due != LEN_NONE,
    (state_r.total == LEN_TWO && state_r.due == LEN_ONE) ||
    (state_r.total == LEN_THREE && state_r.due != LEN_NONE), "bad sequence state")
  // A result made by the decode step is presented on the next cycle.
  `U8B_ASSERT_NXT(a_res_shown, advance && step_res.valid, out_tvalid,
    "decoded result lost")

endmodule
`default_nettype wire
